@@ hdl/nrm_pkg.sv @@
// ---------------------------------------------------------------------------
// nrm_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, the cordic arctangent table and the rounding
// functions used by the normal to rotation matrix pipeline.
// ---------------------------------------------------------------------------
package nrm_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int WORK_FRAC      = 30;
	localparam int CORDIC_STEPS   = 30;
	localparam int STEP_W         = 5;
	localparam int CW             = 34;  // cordic datapath width
	localparam int QB             = 34;  // quotient bits kept by the divider
	localparam int RW             = 36;  // width of a matrix entry before output rounding
	localparam int OUT_W          = COEF_FRAC_BITS + 2;
	localparam int NUM_ENTRIES    = 9;

	localparam logic signed [CW-1:0] GAIN_Q30 = CW'(34'sh026DD3B6A);

	// one cordic cell's payload
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cordic_t;

	// one divider cell's payload
	typedef struct packed {
		logic [31:0]    dvs;
		logic [31:0]    rem;
		logic [QB-1:0]  low;
		logic [QB-1:0]  quo;
		logic           ovf;
	} div_t;

	// values that ride alongside the divider chain
	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic               dgn;
		logic               nxy_neg;
	} side_t;

	// arctangent of 2^-i in 2^32-per-turn units
	function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return signed'({2'b00, v});
	endfunction

	// Q60 product back to Q30, half away from zero
	function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] r;
		m = p[63] ? 64'(-p) : 64'(p);
		r = (m + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
		return p[63] ? 32'(-r) : 32'(r);
	endfunction

	// Q30 entry to the output format, half away from zero, saturated
	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [RW-1:0] v);
		localparam int SH = WORK_FRAC - COEF_FRAC_BITS;
		logic [RW-1:0] m;
		logic [RW-1:0] r;
		m = v[RW-1] ? RW'(-v) : RW'(v);
		r = (m + (RW'(1) << (SH - 1))) >> SH;
		if (r > (RW'(1) << COEF_FRAC_BITS))
			r = RW'(1) << COEF_FRAC_BITS;
		return v[RW-1] ? OUT_W'(-r) : OUT_W'(r);
	endfunction

endpackage

@@ hdl/nrm_in_if.sv @@
// ---------------------------------------------------------------------------
// nrm_in_if: angle pair channel
// Valid/ready channel carrying the azimuth and polar angle of one normal.
// ---------------------------------------------------------------------------
interface nrm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] azimuth_angle;
	logic [15:0] polar_angle;

	modport source (output valid, output azimuth_angle, output polar_angle, input ready);
	modport sink   (input valid, input azimuth_angle, input polar_angle, output ready);
endinterface

@@ hdl/nrm_out_if.sv @@
// ---------------------------------------------------------------------------
// nrm_out_if: rotation matrix channel
// Valid/ready channel carrying the nine Q1.14 entries and the degenerate flag.
// ---------------------------------------------------------------------------
interface nrm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r_row0_col0;
	logic signed [15:0] r_row0_col1;
	logic signed [15:0] r_row0_col2;
	logic signed [15:0] r_row1_col0;
	logic signed [15:0] r_row1_col1;
	logic signed [15:0] r_row1_col2;
	logic signed [15:0] r_row2_col0;
	logic signed [15:0] r_row2_col1;
	logic signed [15:0] r_row2_col2;
	logic               degenerate;

	modport source (output valid, input ready,
		output r_row0_col0, output r_row0_col1, output r_row0_col2,
		output r_row1_col0, output r_row1_col1, output r_row1_col2,
		output r_row2_col0, output r_row2_col1, output r_row2_col2,
		output degenerate);
	modport sink (input valid, output ready,
		input r_row0_col0, input r_row0_col1, input r_row0_col2,
		input r_row1_col0, input r_row1_col1, input r_row1_col2,
		input r_row2_col0, input r_row2_col1, input r_row2_col2,
		input degenerate);
endinterface

@@ hdl/normal_to_rotation_matrix.sv @@
// ---------------------------------------------------------------------------
// normal_to_rotation_matrix: rotation taking a spherical normal onto -z
// Forms the normal from azimuth and polar angle and returns the Rodrigues
// rotation matrix in signed Q1.14, or the identity for a degenerate normal.
// ---------------------------------------------------------------------------
// One angle pair is accepted every cycle unless a stalled output beat holds the
// pipeline. Its matrix passes through two rows of 30 cordic cells (sine and cosine
// of each angle), four stages of multiply and rounding, a row of 34 restoring
// divider cells per quotient and one output register. A stalled output beat
// freezes the whole pipeline, so ready on the input follows the output side.
module normal_to_rotation_matrix import nrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	nrm_in_if.sink    req,
	nrm_out_if.source rsp
);

	localparam int P1  = CORDIC_STEPS;
	localparam int P4  = P1 + 3;
	localparam int LAT = P4 + QB + 2;
	localparam int NDIV = 4;

	logic           en;
	logic [LAT-1:0] vld_q;

	// pipeline advance, frozen while the output beat waits
	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], req.valid};
	end

	// quadrant fold and cordic seed for both angles
	cordic_t seed_az;
	cordic_t seed_pl;

	function automatic cordic_t make_seed(input logic [ANGLE_BITS-1:0] ang);
		cordic_t     s;
		logic [31:0] a;
		logic [31:0] df;
		logic [31:0] af;
		a  = {ang, {(32 - ANGLE_BITS){1'b0}}};
		df = a - 32'h4000_0000;
		s.flip = !df[31];
		af = s.flip ? a - 32'h8000_0000 : a;
		s.x = GAIN_Q30;
		s.y = '0;
		s.z = signed'({{(CW - 32){af[31]}}, af});
		return s;
	endfunction

	assign seed_az = make_seed(req.azimuth_angle);
	assign seed_pl = make_seed(req.polar_angle);

	// two rows of cordic cells
	cordic_t ca_q [CORDIC_STEPS];
	cordic_t cp_q [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		nrm_cordic_cell u_az (
			.clk   (clk),
			.en    (en),
			.step  (STEP_W'(k)),
			.d_in  ((k == 0) ? seed_az : ca_q[(k == 0) ? 0 : k - 1]),
			.d_out (ca_q[k])
		);
		nrm_cordic_cell u_pl (
			.clk   (clk),
			.en    (en),
			.step  (STEP_W'(k)),
			.d_in  ((k == 0) ? seed_pl : cp_q[(k == 0) ? 0 : k - 1]),
			.d_out (cp_q[k])
		);
	end

	// unfold quadrant, then cos az * sin pol and sin az * sin pol
	logic signed [31:0] cos_az;
	logic signed [31:0] sin_az;
	logic signed [31:0] cos_pl;
	logic signed [31:0] sin_pl;
	logic signed [63:0] px_s1;
	logic signed [63:0] py_s1;
	logic signed [31:0] cp_s1;

	always_comb begin
		cos_az = ca_q[CORDIC_STEPS-1].flip ? 32'(-ca_q[CORDIC_STEPS-1].x)
			: 32'(ca_q[CORDIC_STEPS-1].x);
		sin_az = ca_q[CORDIC_STEPS-1].flip ? 32'(-ca_q[CORDIC_STEPS-1].y)
			: 32'(ca_q[CORDIC_STEPS-1].y);
		cos_pl = cp_q[CORDIC_STEPS-1].flip ? 32'(-cp_q[CORDIC_STEPS-1].x)
			: 32'(cp_q[CORDIC_STEPS-1].x);
		sin_pl = cp_q[CORDIC_STEPS-1].flip ? 32'(-cp_q[CORDIC_STEPS-1].y)
			: 32'(cp_q[CORDIC_STEPS-1].y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= cos_az * sin_pl;
			py_s1 <= sin_az * sin_pl;
			cp_s1 <= cos_pl;
		end
	end

	// normal in Q30, d = 1 - c and the degenerate test
	logic signed [31:0] nx_s2;
	logic signed [31:0] ny_s2;
	logic [31:0]        d_s2;
	logic               dg_s2;
	logic signed [33:0] d_full;

	assign d_full = (34'sd1 <<< WORK_FRAC) - 34'(cp_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= round_q30(px_s1);
			ny_s2 <= round_q30(py_s1);
			d_s2  <= d_full[31:0];
			dg_s2 <= d_full < (34'sd1 <<< (WORK_FRAC - COEF_FRAC_BITS));
		end
	end

	// second-order products of the normal
	logic signed [63:0] nxx_s3;
	logic signed [63:0] nxy_s3;
	logic signed [63:0] nyy_s3;
	side_t              sd_s3;
	logic [31:0]        d_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nxx_s3     <= nx_s2 * nx_s2;
			nxy_s3     <= nx_s2 * ny_s2;
			nyy_s3     <= ny_s2 * ny_s2;
			sd_s3.nx   <= nx_s2;
			sd_s3.ny   <= ny_s2;
			sd_s3.dgn  <= dg_s2;
			sd_s3.nxy_neg <= 1'b0;
			d_s3       <= d_s2;
		end
	end

	// rounded numerators and divider seeds
	logic [63:0] num [NDIV];
	div_t        seed_dv [NDIV];
	div_t        dv_s4 [NDIV];
	side_t       side_q [QB + 1];

	always_comb begin
		num[0] = 64'(nxx_s3) + 64'(d_s3 >> 1);
		num[1] = (nxy_s3[63] ? 64'(-nxy_s3) : 64'(nxy_s3)) + 64'(d_s3 >> 1);
		num[2] = 64'(nyy_s3) + 64'(d_s3 >> 1);
		num[3] = 64'(nxx_s3) + 64'(nyy_s3) + 64'(d_s3 >> 1);
		for (int j = 0; j < NDIV; j++) begin
			seed_dv[j].dvs = d_s3;
			seed_dv[j].ovf = {2'b00, num[j][63:QB]} >= d_s3;
			seed_dv[j].rem = 32'(num[j][63:QB]);
			seed_dv[j].low = num[j][QB-1:0];
			seed_dv[j].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s4     <= seed_dv;
			side_q[0] <= '{nx: sd_s3.nx, ny: sd_s3.ny, dgn: sd_s3.dgn,
				nxy_neg: nxy_s3[63]};
			for (int k = 1; k <= QB; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	// four rows of divider cells
	div_t dq [NDIV][QB];

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		for (genvar k = 0; k < QB; k++) begin : g_cell
			nrm_div_cell u_cell (
				.clk   (clk),
				.en    (en),
				.d_in  ((k == 0) ? dv_s4[j] : dq[j][(k == 0) ? 0 : k - 1]),
				.d_out (dq[j][k])
			);
		end
	end

	// assemble the matrix, identity for a degenerate normal
	logic signed [RW-1:0] qv [NDIV];
	logic signed [RW-1:0] rm [NUM_ENTRIES];
	logic signed [RW-1:0] one_q30;
	logic signed [RW-1:0] nxe;
	logic signed [RW-1:0] nye;
	side_t                sd_end;
	logic signed [OUT_W-1:0] out_q [NUM_ENTRIES];
	logic                 dg_q;

	assign one_q30 = RW'(1) << WORK_FRAC;
	assign sd_end  = side_q[QB];
	assign nxe     = RW'(sd_end.nx);
	assign nye     = RW'(sd_end.ny);

	always_comb begin
		for (int j = 0; j < NDIV; j++)
			qv[j] = dq[j][QB-1].ovf ? signed'(RW'({QB{1'b1}}))
				: signed'(RW'(dq[j][QB-1].quo));
		if (sd_end.dgn) begin
			for (int k = 0; k < NUM_ENTRIES; k++)
				rm[k] = (k % 4 == 0) ? one_q30 : '0;
		end else begin
			rm[0] = one_q30 - qv[0];
			rm[1] = sd_end.nxy_neg ? qv[1] : -qv[1];
			rm[2] = nxe;
			rm[3] = rm[1];
			rm[4] = one_q30 - qv[2];
			rm[5] = nye;
			rm[6] = -nxe;
			rm[7] = -nye;
			rm[8] = one_q30 - qv[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_ENTRIES; k++)
				out_q[k] <= to_out(rm[k]);
			dg_q <= sd_end.dgn;
		end
	end

	assign rsp.r_row0_col0 = out_q[0];
	assign rsp.r_row0_col1 = out_q[1];
	assign rsp.r_row0_col2 = out_q[2];
	assign rsp.r_row1_col0 = out_q[3];
	assign rsp.r_row1_col1 = out_q[4];
	assign rsp.r_row1_col2 = out_q[5];
	assign rsp.r_row2_col0 = out_q[6];
	assign rsp.r_row2_col1 = out_q[7];
	assign rsp.r_row2_col2 = out_q[8];
	assign rsp.degenerate  = dg_q;

endmodule

@@ hdl/nrm_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// nrm_cordic_cell: one cordic rotation step
// Rotates (x, y) by plus or minus atan(2^-step) depending on the sign of z
// and registers the result for the next cell.
// ---------------------------------------------------------------------------
module nrm_cordic_cell import nrm_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  cordic_t           d_in,
	output cordic_t           d_out
);

	cordic_t              nxt;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] at;

	// rotation direction follows the residual angle
	always_comb begin
		xs = d_in.x >>> step;
		ys = d_in.y >>> step;
		at = atan_turn(step);
		nxt.flip = d_in.flip;
		if (!d_in.z[CW-1]) begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - at;
		end else begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end

endmodule

@@ hdl/nrm_div_cell.sv @@
// ---------------------------------------------------------------------------
// nrm_div_cell: one restoring division step
// Brings down one numerator bit, subtracts the divisor when it fits and
// shifts the quotient bit in.
// ---------------------------------------------------------------------------
module nrm_div_cell import nrm_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	div_t        nxt;
	logic [32:0] trial;
	logic        fits;

	// trial subtract of the partial remainder
	always_comb begin
		trial = {d_in.rem, d_in.low[QB-1]};
		fits  = trial >= {1'b0, d_in.dvs};
		nxt.dvs = d_in.dvs;
		nxt.ovf = d_in.ovf;
		nxt.low = {d_in.low[QB-2:0], 1'b0};
		nxt.quo = {d_in.quo[QB-2:0], fits};
		nxt.rem = fits ? 32'(trial - {1'b0, d_in.dvs}) : trial[31:0];
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end

endmodule

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for normal_to_rotation_matrix
// Drives angle pairs through a queue-fed driver, predicts each rotation
// matrix with a cordic and Rodrigues model at the block's widths, and checks
// every output beat in order under random idling and back-pressure.
// ---------------------------------------------------------------------------
module tb_top;
	import nrm_pkg::*;

	localparam int LATENCY   = 69;
	localparam int WD_LIMIT  = 20000;
	localparam int N_RANDOM  = 1530;
	localparam int HOLD_LEN  = 300;

	typedef struct {
		logic [15:0] az;
		logic [15:0] pol;
	} angles_t;

	typedef struct {
		logic signed [15:0] r [9];
		logic               dgn;
	} matrix_t;

	logic clk;
	logic arst_n;

	nrm_in_if  req ();
	nrm_out_if rsp ();

	normal_to_rotation_matrix i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	angles_t pending_angles [$];
	matrix_t expected_matrices [$];
	int      mismatch_count;
	int      idle_phase;       // 0: receiver idles more, 1: sender more, 2: none
	bit      hold_rsp;         // long receiver hold-off request
	bit      pause_src;        // sender pause until drained
	int      hold_cnt;
	int      wd_cnt;

	// arctangent of 2^-i in 2^32-per-turn units
	function automatic longint atan_step(int i);
		longint tbl [30] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
		return tbl[i];
	endfunction

	// floor shift for signed values
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (s ? (64'sd1 <<< (s - 1)) : 0)) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = (m + den / 2) / den;
		return (num < 0) ? -m : m;
	endfunction

	// cordic sine and cosine in Q30 of a 16-bit turn fraction
	task automatic cordic_sincos(input logic [15:0] ang, output longint cs, output longint sn);
		logic [31:0] a;
		bit          flip;
		longint      x, y, z, t;
		a = {ang, 16'h0000};
		flip = (a - 32'h40000000) < 32'h80000000;
		if (flip)
			a = a - 32'h80000000;
		z = a[31] ? longint'(a) - (64'sd1 <<< 32) : longint'(a);
		x = 64'h26DD3B6A;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				t = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z = z - atan_step(i);
			end else begin
				t = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z = z + atan_step(i);
			end
			x = t;
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endtask

	function automatic logic signed [15:0] entry_q14(longint v);
		longint r;
		r = round_shift(v, WORK_FRAC - COEF_FRAC_BITS);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[15:0];
	endfunction

	task automatic predict_matrix(input angles_t a, output matrix_t m);
		longint ca, sa, cp, sp, nx, ny, d, one;
		longint e [9];
		one = 64'sd1 <<< WORK_FRAC;
		cordic_sincos(a.az, ca, sa);
		cordic_sincos(a.pol, cp, sp);
		nx = round_shift(ca * sp, WORK_FRAC);
		ny = round_shift(sa * sp, WORK_FRAC);
		d = one - cp;
		if (d < (64'sd1 <<< (WORK_FRAC - COEF_FRAC_BITS))) begin
			for (int k = 0; k < 9; k++)
				e[k] = (k % 4 == 0) ? one : 0;
			m.dgn = 1'b1;
		end else begin
			e[0] = one - round_div(nx * nx, d);
			e[1] = -round_div(nx * ny, d);
			e[2] = nx;
			e[3] = e[1];
			e[4] = one - round_div(ny * ny, d);
			e[5] = ny;
			e[6] = -nx;
			e[7] = -ny;
			e[8] = one - round_div(nx * nx + ny * ny, d);
			m.dgn = 1'b0;
		end
		for (int k = 0; k < 9; k++)
			m.r[k] = entry_q14(e[k]);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic push_angles(input logic [15:0] az, input logic [15:0] pol);
		angles_t a;
		a.az = az;
		a.pol = pol;
		pending_angles.push_back(a);
	endtask

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// driver: offers queued beats, idling by phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.azimuth_angle <= '0;
			req.polar_angle <= '0;
		end else begin
			if (!req.valid || req.ready) begin
				matrix_t m;
				if (req.valid && req.ready) begin
					predict_matrix('{req.azimuth_angle, req.polar_angle}, m);
					expected_matrices.push_back(m);
				end
				if (pending_angles.size() != 0 && !pause_src &&
						!(idle_phase == 0 && $urandom_range(99) < 36) &&
						!(idle_phase == 1 && $urandom_range(99) < 47)) begin
					angles_t a;
					a = pending_angles.pop_front();
					req.valid <= 1'b1;
					req.azimuth_angle <= a.az;
					req.polar_angle <= a.pol;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with a long hold-off counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_rsp && hold_cnt < HOLD_LEN) begin
			rsp.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			if (!hold_rsp)
				hold_cnt <= 0;
			case (idle_phase)
				0: rsp.ready <= $urandom_range(99) >= 47;
				1: rsp.ready <= $urandom_range(99) >= 36;
				default: rsp.ready <= 1'b1;
			endcase
		end
	end

	// monitor: compare each output beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_matrices.size() == 0) begin
				report_mismatch("unexpected beat", 0, 0);
			end else begin
				matrix_t w;
				logic signed [15:0] g [9];
				w = expected_matrices.pop_front();
				g = '{rsp.r_row0_col0, rsp.r_row0_col1, rsp.r_row0_col2,
					rsp.r_row1_col0, rsp.r_row1_col1, rsp.r_row1_col2,
					rsp.r_row2_col0, rsp.r_row2_col1, rsp.r_row2_col2};
				for (int k = 0; k < 9; k++)
					if (g[k] !== w.r[k])
						report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), g[k], w.r[k]);
				if (rsp.degenerate !== w.dgn)
					report_mismatch("degenerate", rsp.degenerate, w.dgn);
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			wd_cnt <= 0;
		else begin
			wd_cnt <= wd_cnt + 1;
			if (wd_cnt >= WD_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_angles.size() != 0 || req.valid || expected_matrices.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		mismatch_count = 0;
		idle_phase = 0;
		hold_rsp = 0;
		pause_src = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, quadrant edges, degenerate pole and near-pole
		push_angles(16'h0000, 16'h0000);
		push_angles(16'hFFFF, 16'hFFFF);
		push_angles(16'h0000, 16'h0001);
		push_angles(16'h1234, 16'h0001);
		push_angles(16'h0000, 16'h0002);
		push_angles(16'h4000, 16'h4000);
		push_angles(16'h8000, 16'h8000);
		push_angles(16'hC000, 16'h4000);
		push_angles(16'h2000, 16'h2000);
		push_angles(16'h3FFF, 16'h3FFF);
		push_angles(16'h4001, 16'hC000);
		push_angles(16'hBFFF, 16'h7FFF);
		push_angles(16'h8001, 16'hC001);
		push_angles(16'hFFFF, 16'h8000);
		push_angles(16'hAAAA, 16'h5555);
		push_angles(16'h5555, 16'hAAAA);
		push_angles(16'h0000, 16'hFFFE);
		push_angles(16'h6000, 16'hE000);
		wait_drained();

		// random, three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			idle_phase = ph;
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				if ($urandom_range(9) == 0)
					push_angles(16'($urandom), ($urandom_range(1) ? 16'h0000 : 16'hFFFF) ^
						16'($urandom_range(7)));
				else
					push_angles(16'($urandom), 16'($urandom));
			end
			if (ph == 0) begin
				// long receiver hold-off while the sender keeps offering
				repeat (20) @(posedge clk);
				hold_rsp = 1;
				while (hold_cnt < HOLD_LEN)
					@(posedge clk);
				hold_rsp = 0;
			end
			if (ph == 1) begin
				// sender pause until everything in flight has come out
				while (pending_angles.size() > N_RANDOM / 6)
					@(posedge clk);
				pause_src = 1;
				while (req.valid || expected_matrices.size() != 0)
					@(posedge clk);
				pause_src = 0;
			end
			wait_drained();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/nrm_pkg.sv
hdl/nrm_in_if.sv
hdl/nrm_out_if.sv
hdl/nrm_cordic_cell.sv
hdl/nrm_div_cell.sv
hdl/normal_to_rotation_matrix.sv
sim/tb_top.sv
